>>> design/pixel_channel_remap_alpha_blend_unit_assert.svh
// Assertion macros for the pixel remap and blend RTL.
// Included by modules that check their own pipeline timing; no dependencies.
`ifndef PIXEL_CHANNEL_REMAP_ALPHA_BLEND_UNIT_ASSERT_SVH
`define PIXEL_CHANNEL_REMAP_ALPHA_BLEND_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PCRAB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcrab: implication check failed");

// Antecedent implies consequent after the delay given by the dly argument.
`define PCRAB_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("pcrab: latency check failed");

// Expression never holds out of reset.
`define PCRAB_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pcrab: forbidden condition seen");

`endif

>>> design/pcrab_pkg.sv
// Shared types, register indexes and byte helpers for the pixel remap/blend unit.
// No dependencies.
package pcrab_pkg;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NCHAN   = 4;
  localparam int unsigned PROD_W  = 17;

  // channel slots in a channel array
  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;
  localparam logic [1:0] CH_A = 2'd3;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [8:0]        ALPHA_ONE    = 9'd256;

  typedef enum logic [2:0] {
    REG_SRC_RED   = 3'd0,
    REG_SRC_GREEN = 3'd1,
    REG_SRC_BLUE  = 3'd2,
    REG_SRC_ALPHA = 3'd3,
    REG_DST_RED   = 3'd4,
    REG_DST_GREEN = 3'd5,
    REG_DST_BLUE  = 3'd6,
    REG_DST_ALPHA = 3'd7
  } reg_idx_t;

  typedef logic [NCHAN-1:0][BYTE_W-1:0] chan_t;

  typedef struct packed {
    logic [NCHAN-1:0][1:0] src_pos;
    logic [NCHAN-1:0][1:0] dst_pos;   // alpha slot holds the low bits of dst alpha
    logic                  dst_alpha_off;  // sign bit of the dst alpha position
  } cfg_t;

  function automatic logic [BYTE_W-1:0] take_byte(input logic [PIX_W-1:0] word,
                                                  input logic [1:0] pos);
    logic [PIX_W-1:0] sh;
    sh = word >> {pos, 3'b000};
    return sh[BYTE_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] place_byte(input logic [BYTE_W-1:0] val,
                                                  input logic [1:0] pos);
    return {24'd0, val} << {pos, 3'b000};
  endfunction

endpackage

>>> design/pcrab_unpack.sv
// Stage 1: pull channel bytes out of the source and destination words.
// Depends on pcrab_pkg.
module pcrab_unpack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcrab_pkg::cfg_t               cfg,
  input  logic                          in_valid,
  input  logic [pcrab_pkg::PIX_W-1:0]   src_pixel,
  input  logic [pcrab_pkg::PIX_W-1:0]   dst_pixel,
  input  logic                          blend,
  output logic                          valid_r,
  output pcrab_pkg::chan_t              src_ch_r,
  output pcrab_pkg::chan_t              dst_ch_r,
  output logic                          blend_r
);
  import pcrab_pkg::*;

  chan_t src_ch_nxt;
  chan_t dst_ch_nxt;

  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      src_ch_nxt[i] = take_byte(src_pixel, cfg.src_pos[i]);
      dst_ch_nxt[i] = take_byte(dst_pixel, cfg.dst_pos[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    src_ch_r <= src_ch_nxt;
    dst_ch_r <= dst_ch_nxt;
    blend_r  <= blend;
  end

endmodule

>>> design/pcrab_mix.sv
// Stages 2 and 3: multiply by source alpha and its complement, then sum and scale.
// Depends on pcrab_pkg.
module pcrab_mix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pcrab_pkg::chan_t  src_ch,
  input  pcrab_pkg::chan_t  dst_ch,
  input  logic              blend,
  output logic              valid_r,
  output pcrab_pkg::chan_t  mix_ch_r
);
  import pcrab_pkg::*;

  logic [2:0][PROD_W-1:0] ps_nxt, ps_r;
  logic [2:0][PROD_W-1:0] pd_nxt, pd_r;
  chan_t                  src_r;
  logic                   blend_r;
  logic                   prod_valid_r;
  logic [8:0]             inv_a;
  logic [2:0][PROD_W-1:0] sum;
  chan_t                  mix_ch_nxt;

  assign inv_a = ALPHA_ONE - {1'b0, src_ch[CH_A]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ps_nxt[i] = {9'd0, src_ch[i]} * {9'd0, src_ch[CH_A]};
      pd_nxt[i] = {9'd0, dst_ch[i]} * {8'd0, inv_a};
    end
  end

  always_ff @(posedge clk) begin
    ps_r    <= ps_nxt;
    pd_r    <= pd_nxt;
    src_r   <= src_ch;
    blend_r <= blend;
  end

  // sum never exceeds 255*256, so bits 15:8 are the scaled channel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i]        = ps_r[i] + pd_r[i];
      mix_ch_nxt[i] = blend_r ? sum[i][15:8] : src_r[i];
    end
    mix_ch_nxt[CH_A] = blend_r ? ALPHA_OPAQUE : src_r[CH_A];
  end

  always_ff @(posedge clk) begin
    mix_ch_r <= mix_ch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      valid_r      <= 1'b0;
    end else begin
      prod_valid_r <= in_valid;
      valid_r      <= prod_valid_r;
    end
  end

endmodule

>>> design/pcrab_pack.sv
// Stage 4: place channel bytes at destination positions and sum into the word.
// Depends on pcrab_pkg.
module pcrab_pack (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcrab_pkg::cfg_t              cfg,
  input  logic                         in_valid,
  input  pcrab_pkg::chan_t             mix_ch,
  output logic                         valid_r,
  output logic [pcrab_pkg::PIX_W-1:0]  pixel_r
);
  import pcrab_pkg::*;

  logic [PIX_W-1:0] alpha_word;
  logic [PIX_W-1:0] pixel_nxt;

  // drop alpha when the destination alpha position is negative
  assign alpha_word = cfg.dst_alpha_off ? '0 : place_byte(mix_ch[CH_A], cfg.dst_pos[CH_A]);

  // shared positions add, carries ripple up and fall off the top byte
  assign pixel_nxt = place_byte(mix_ch[CH_R], cfg.dst_pos[CH_R])
                   + place_byte(mix_ch[CH_G], cfg.dst_pos[CH_G])
                   + place_byte(mix_ch[CH_B], cfg.dst_pos[CH_B])
                   + alpha_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

endmodule

>>> design/pixel_channel_remap_alpha_blend_unit.sv
// Channel         | Ports                                        | Handshake
// input word      | in_src_pixel, in_dst_pixel, in_blend         | start, busy
// result word     | out_pixel                                    | out_valid strobe
// register write  | cfg_index, cfg_data                          | cfg_valid, cfg_ready
//
// One word enters per cycle; busy stays low. The register stages are unpack,
// multiply, sum/scale and pack (the 8x8 and 8x9 multipliers set the stage
// depth). out_valid marks each result for exactly one cycle.
// Synchronous active-low reset clears the stage valid bits and loads the
// default byte order (R0 G1 B2 A3 on both sides). Results cannot be stalled.
// Top level; needs pcrab_pkg, pcrab_unpack, pcrab_mix, pcrab_pack, assert header.
`include "pixel_channel_remap_alpha_blend_unit_assert.svh"
module pixel_channel_remap_alpha_blend_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [pcrab_pkg::PIX_W-1:0]  in_src_pixel,
  input  logic [pcrab_pkg::PIX_W-1:0]  in_dst_pixel,
  input  logic                         in_blend,
  output logic                         out_valid,
  output logic [pcrab_pkg::PIX_W-1:0]  out_pixel,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [2:0]                   cfg_data
);
  import pcrab_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  accept;
  logic  s1_valid, s3_valid;
  chan_t s1_src, s1_dst, s3_mix;
  logic  s1_blend;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SRC_RED:   cfg_nxt.src_pos[CH_R] = cfg_data[1:0];
        REG_SRC_GREEN: cfg_nxt.src_pos[CH_G] = cfg_data[1:0];
        REG_SRC_BLUE:  cfg_nxt.src_pos[CH_B] = cfg_data[1:0];
        REG_SRC_ALPHA: cfg_nxt.src_pos[CH_A] = cfg_data[1:0];
        REG_DST_RED:   cfg_nxt.dst_pos[CH_R] = cfg_data[1:0];
        REG_DST_GREEN: cfg_nxt.dst_pos[CH_G] = cfg_data[1:0];
        REG_DST_BLUE:  cfg_nxt.dst_pos[CH_B] = cfg_data[1:0];
        REG_DST_ALPHA: begin
          cfg_nxt.dst_pos[CH_A] = cfg_data[1:0];
          cfg_nxt.dst_alpha_off = cfg_data[2];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_pos       <= {CH_A, CH_B, CH_G, CH_R};
      cfg_r.dst_pos       <= {CH_A, CH_B, CH_G, CH_R};
      cfg_r.dst_alpha_off <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pcrab_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (accept),
    .src_pixel (in_src_pixel),
    .dst_pixel (in_dst_pixel),
    .blend     (in_blend),
    .valid_r   (s1_valid),
    .src_ch_r  (s1_src),
    .dst_ch_r  (s1_dst),
    .blend_r   (s1_blend)
  );

  pcrab_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid),
    .src_ch   (s1_src),
    .dst_ch   (s1_dst),
    .blend    (s1_blend),
    .valid_r  (s3_valid),
    .mix_ch_r (s3_mix)
  );

  pcrab_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (s3_valid),
    .mix_ch   (s3_mix),
    .valid_r  (out_valid),
    .pixel_r  (out_pixel)
  );

  `PCRAB_ASSERT_DELAY(a_accept_to_out, clk, rst_n, accept, 4, out_valid)
  `PCRAB_ASSERT_IMPLY(a_out_has_source, clk, rst_n, out_valid, $past(accept && rst_n, 4))
  `PCRAB_ASSERT_IMPLY(a_stage_order, clk, rst_n, s3_valid, $past(s1_valid, 2))
  `PCRAB_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)

endmodule

>>> test/testbench.sv
// Self-checking bench for pixel_channel_remap_alpha_blend_unit: random and directed
// pixel words under several byte-order settings, scored against a built-in predictor.
// Depends on pcrab_pkg and the unit RTL.
module testbench;
  import pcrab_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] dst;
    logic             blend;
  } pix_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [PIX_W-1:0] in_src_pixel = '0;
  logic [PIX_W-1:0] in_dst_pixel = '0;
  logic             in_blend = 1'b0;
  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  reg_idx_t         cfg_index = REG_SRC_RED;
  logic [2:0]       cfg_data = '0;

  pix_word_t        pending_words[$];
  logic [PIX_W-1:0] expected_pixels[$];

  // byte order as the unit should hold it
  logic [1:0] src_at [NCHAN];
  logic [1:0] dst_at [3];
  logic [2:0] dst_alpha_at;

  int unsigned queued_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned blend_cnt = 0;
  int unsigned cfg_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_left = 0;
  int unsigned burst_left = 0;

  pixel_channel_remap_alpha_blend_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_src_pixel (in_src_pixel),
    .in_dst_pixel (in_dst_pixel),
    .in_blend     (in_blend),
    .out_valid    (out_valid),
    .out_pixel    (out_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [PIX_W-1:0] blend_pixel(input logic [PIX_W-1:0] src,
                                                   input logic [PIX_W-1:0] dst,
                                                   input logic blend);
    logic [BYTE_W-1:0] s_ch [NCHAN];
    logic [BYTE_W-1:0] o_ch [NCHAN];
    int unsigned       a;
    int unsigned       d;
    logic [PIX_W-1:0]  word;
    for (int c = 0; c < NCHAN; c++) s_ch[c] = src[8*src_at[c] +: 8];
    a = s_ch[CH_A];
    if (blend) begin
      for (int c = 0; c < 3; c++) begin
        d = dst[8*dst_at[c] +: 8];
        o_ch[c] = 8'((s_ch[c] * a + d * (256 - a)) >> 8);
      end
      o_ch[CH_A] = 8'hff;
    end else begin
      o_ch = s_ch;
    end
    // shared positions add up and carry into the next byte; top carry is lost
    word = '0;
    for (int c = 0; c < 3; c++) word += {24'd0, o_ch[c]} << (8*dst_at[c]);
    if (!dst_alpha_at[2]) word += {24'd0, o_ch[CH_A]} << (8*dst_alpha_at[1:0]);
    return word;
  endfunction

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                 input logic [PIX_W-1:0] want);
    err_cnt++;
    if (err_cnt <= 50) $display("mismatch: %s: got %08h want %08h", what, got, want);
  endtask

  function automatic int unsigned gap_after_word();
    int unsigned pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: hold the word until accepted, then idle or advance.
  always @(negedge clk) begin : drive_words
    pix_word_t nxt;
    if (rst_n && !(start && taken_cnt != sent_cnt)) begin
      if (start) idle_left = gap_after_word();
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_words.size() > 0) begin
        nxt = pending_words.pop_front();
        in_src_pixel <= nxt.src;
        in_dst_pixel <= nxt.dst;
        in_blend     <= nxt.blend;
        start        <= 1'b1;
        sent_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on acceptance, score results, track register writes.
  always @(posedge clk) begin : watch_unit
    logic [PIX_W-1:0] want;
    if (!rst_n) begin
      src_at       = '{2'd0, 2'd1, 2'd2, 2'd3};
      dst_at       = '{2'd0, 2'd1, 2'd2};
      dst_alpha_at = 3'd3;
    end else begin
      if (start && !busy) begin
        expected_pixels.push_back(blend_pixel(in_src_pixel, in_dst_pixel, in_blend));
        taken_cnt++;
        if (in_blend) blend_cnt++;
      end
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with no word pending", out_pixel, 'x);
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel !== want) report_mismatch("out_pixel", out_pixel, want);
          checked_cnt++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_RED:   src_at[CH_R] = cfg_data[1:0];
          REG_SRC_GREEN: src_at[CH_G] = cfg_data[1:0];
          REG_SRC_BLUE:  src_at[CH_B] = cfg_data[1:0];
          REG_SRC_ALPHA: src_at[CH_A] = cfg_data[1:0];
          REG_DST_RED:   dst_at[CH_R] = cfg_data[1:0];
          REG_DST_GREEN: dst_at[CH_G] = cfg_data[1:0];
          REG_DST_BLUE:  dst_at[CH_B] = cfg_data[1:0];
          REG_DST_ALPHA: dst_alpha_at = cfg_data;
          default: ;
        endcase
        cfg_cnt++;
      end
    end
  end

  task automatic add_word(input logic [PIX_W-1:0] s, input logic [PIX_W-1:0] d,
                          input logic b);
    pending_words.push_back('{s, d, b});
    queued_cnt++;
  endtask

  // Wait until every queued word is taken and scored, then let the pipe empty.
  task automatic drain();
    do @(negedge clk); while (taken_cnt != queued_cnt || expected_pixels.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [2:0] val);
    int unsigned seen;
    seen = cfg_cnt;
    repeat ($urandom_range(0, 3)) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (cfg_cnt == seen);
    cfg_valid <= 1'b0;
  endtask

  // vals[7] is dst alpha down to vals[0] src red
  task automatic cfg_set(input logic [7:0][2:0] vals);
    for (int r = 0; r < 8; r++) cfg_write(reg_idx_t'(r), vals[r]);
  endtask

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h00;
      2, 3:    return 8'hff;
      4:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_word();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  initial begin
    logic [7:0][2:0] setting;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // default order: extremes, alpha 0 / 128 / 255, dst alpha byte ignored
    add_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    add_word(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_word(32'hffff_ffff, 32'h0000_0000, 1'b1);
    add_word(32'h00ff_ffff, 32'h1234_5678, 1'b1);
    add_word(32'h80ff_00ff, 32'h0000_ff00, 1'b1);
    add_word(32'h1122_3344, 32'hff00_0000, 1'b1);
    add_word(32'ha5a5_a5a5, 32'h5a5a_5a5a, 1'b0);
    drain();

    // reversed source, every destination channel in the top byte
    cfg_set({3'd3, 3'd3, 3'd3, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3});
    add_word(32'hffff_ffff, 32'h0000_0000, 1'b0);
    add_word(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    add_word(32'h8040_2010, 32'h0000_0000, 1'b1);
    drain();

    // everything in byte zero: carries ripple upward
    cfg_set('0);
    add_word(32'h0000_00ff, 32'h0000_00ff, 1'b0);
    add_word(32'h0000_00ff, 32'h0000_0000, 1'b1);
    add_word(32'h0000_007f, 32'h0000_00c0, 1'b1);
    drain();

    // BGR destination without alpha byte
    cfg_set({3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd2, 3'd1, 3'd0});
    add_word(32'h8011_2233, 32'h4455_6677, 1'b1);
    add_word(32'hffff_ffff, 32'h0000_0000, 1'b0);
    drain();

    // most negative alpha position; upper data bit set on a position write
    cfg_write(REG_DST_ALPHA, 3'd4);
    cfg_write(REG_DST_RED, 3'b101);
    add_word(32'hdead_beef, 32'h0123_4567, 1'b0);
    add_word(32'hdead_beef, 32'h0123_4567, 1'b1);
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p == 0) setting = '0;
      else if (p == 1) setting = {8{3'd3}};
      else for (int r = 0; r < 8; r++) setting[r] = 3'($urandom_range(0, 7));
      for (int r = 0; r < 8; r++) begin
        if (p < 2 || $urandom_range(0, 3) != 0) cfg_write(reg_idx_t'(r), setting[r]);
      end
      for (int n = 0; n < 137; n++) add_word(rand_word(), rand_word(), $urandom_range(0, 2) != 0);
      drain();
    end

    $display("testbench: %0d pixel words (%0d blended), %0d results scored",
             taken_cnt, blend_cnt, checked_cnt);
    $display("testbench: %0d register writes over 17 byte-order settings, %0d mismatches",
             cfg_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/pcrab_pkg.sv
design/pcrab_unpack.sv
design/pcrab_mix.sv
design/pcrab_pack.sv
design/pixel_channel_remap_alpha_blend_unit.sv
test/testbench.sv
